// ----- hw/rtl/slcd_pkg.sv -----
// shared types and constants of the serial lcd command decoder
package slcd_pkg;

   // parser phase codes
   typedef enum logic [3:0] {
      PH_IDLE          = 4'd0,
      PH_TAG           = 4'd1,
      PH_COLUMN        = 4'd2,
      PH_ROW           = 4'd3,
      PH_CONTRAST      = 4'd4,
      PH_CONTRAST_SAVE = 4'd5,
      PH_VERSION       = 4'd6,
      PH_GPO_ON        = 4'd7,
      PH_GPO_OFF       = 4'd8,
      PH_MINUTES       = 4'd9
   } phase_type;

   // result action codes
   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_INSTR    = 3'd1,
      ACT_DATA     = 3'd2,
      ACT_DAC      = 3'd3,
      ACT_DAC_SAVE = 3'd4,
      ACT_GPO      = 3'd5,
      ACT_LIGHT    = 3'd6
   } action_type;

   // configuration register indexes
   localparam logic CSR_TICKS_PER_MINUTE = 1'b0;
   localparam logic CSR_DISPLAY_COLUMNS  = 1'b1;

   localparam logic [15:0] TICKS_PER_MINUTE_RESET = 16'h04B0;
   localparam logic [5:0]  DISPLAY_COLUMNS_RESET  = 6'd20;

   // escape byte and command tags
   localparam logic [7:0] BYTE_ESCAPE      = 8'hFE;
   localparam logic [7:0] TAG_BLOCK_ON     = 8'h4A;
   localparam logic [7:0] TAG_BLOCK_OFF    = 8'h4B;
   localparam logic [7:0] TAG_CLEAR        = 8'h58;
   localparam logic [7:0] TAG_BLINK_ON     = 8'h53;
   localparam logic [7:0] TAG_BLINK_OFF    = 8'h54;
   localparam logic [7:0] TAG_HOME         = 8'h48;
   localparam logic [7:0] TAG_LEFT         = 8'h4C;
   localparam logic [7:0] TAG_RIGHT        = 8'h4D;
   localparam logic [7:0] TAG_LIGHT_OFF    = 8'h46;
   localparam logic [7:0] TAG_POSITION     = 8'h47;
   localparam logic [7:0] TAG_CONTRAST     = 8'h50;
   localparam logic [7:0] TAG_CONTRAST_SAV = 8'h91;
   localparam logic [7:0] TAG_VERSION      = 8'h36;
   localparam logic [7:0] TAG_GPO_ON       = 8'h57;
   localparam logic [7:0] TAG_GPO_OFF      = 8'h56;
   localparam logic [7:0] TAG_LIGHT_ON     = 8'h42;

   // hd44780 instruction bytes
   localparam logic [7:0] INSTR_CURSOR_ON  = 8'h0E;
   localparam logic [7:0] INSTR_CURSOR_OFF = 8'h0C;
   localparam logic [7:0] INSTR_CLEAR      = 8'h01;
   localparam logic [7:0] INSTR_BLINK_ON   = 8'h0F;
   localparam logic [7:0] INSTR_HOME       = 8'h02;
   localparam logic [7:0] INSTR_LEFT       = 8'h10;
   localparam logic [7:0] INSTR_RIGHT      = 8'h14;

   // ddram row base addresses
   localparam logic [7:0] ROW1_BASE = 8'h80;
   localparam logic [7:0] ROW2_BASE = 8'hC0;
   localparam logic [7:0] ROW3_BASE = 8'h94;
   localparam logic [7:0] ROW4_BASE = 8'hD4;

endpackage

// ----- hw/rtl/serial_lcd_command_decoder_unit.sv -----
// serial lcd command decoder: input register, decode, result register
//
//   channel | ports                         | contents
//   --------+-------------------------------+---------------------------------------
//   input   | req_tvalid/tready/tdata/tuser | tuser: mode; tdata: rx_byte
//   result  | rsp_tvalid/tready/tdata/tuser | tuser: action; tdata: out_byte, light_on
//   config  | csr_valid/ready/index/data    | 0 ticks_per_minute, 1 display_columns
//
// one item per cycle while the result is taken; an item passes from the input
// register to the result register once the result register is free, so
// rsp_tvalid rises only after the item has passed through both registers
// the decode and the tick/minute compares sit between the two registers
// reset (synchronous) empties both registers and clears all parser/timer state
// a stalled result holds; one more item waits in the input register, then
// req_tready drops until the result is taken
module serial_lcd_command_decoder_unit
   import slcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] mode

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] light_on, [15:9] zero
   output logic [2:0]  rsp_tuser,   // [2:0] action

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   // configuration
   logic [15:0] ticks_per_minute_ff;
   logic [5:0]  display_columns_ff;

   // input register
   logic        in_valid_ff;
   logic        in_mode_ff;
   logic [7:0]  in_byte_ff;

   // result register
   logic        out_valid_ff;
   action_type  out_action_ff;
   logic [7:0]  out_byte_ff;
   logic        out_light_ff;

   // decoder state
   phase_type   phase_ff, phase_in;
   logic [7:0]  held_column_ff, held_column_in;
   logic [7:0]  gpo_bits_ff, gpo_bits_in;
   logic        relay_ff, relay_in;
   logic        running_ff, running_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic [7:0]  minute_count_ff, minute_count_in;
   logic [7:0]  minute_limit_ff, minute_limit_in;

   action_type  action_in;
   logic [7:0]  obyte_in;

   logic        out_free;
   logic        advance;

   // temporaries of the decode
   logic [15:0] tick_next;
   logic [7:0]  minute_next;
   logic [7:0]  row_base;
   logic [7:0]  gpo_mask;
   logic        sel_ok;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_action_ff;
   assign rsp_tdata  = {7'd0, out_light_ff, out_byte_ff};

   // decode of the item in the input register
   always_comb begin
      phase_in        = phase_ff;
      held_column_in  = held_column_ff;
      gpo_bits_in     = gpo_bits_ff;
      relay_in        = relay_ff;
      running_in      = running_ff;
      tick_count_in   = tick_count_ff;
      minute_count_in = minute_count_ff;
      minute_limit_in = minute_limit_ff;
      action_in       = ACT_NONE;
      obyte_in        = 8'd0;
      tick_next       = tick_count_ff + 16'd1;
      minute_next     = minute_count_ff + 8'd1;
      sel_ok          = (in_byte_ff >= 8'd1) && (in_byte_ff <= 8'd8);
      gpo_mask        = 8'd1 << in_byte_ff[2:0] - 3'd1;

      case (in_byte_ff)
         8'd1:    row_base = ROW1_BASE;
         8'd2:    row_base = ROW2_BASE;
         8'd3:    row_base = ROW3_BASE;
         8'd4:    row_base = ROW4_BASE;
         default: row_base = 8'd0;
      endcase

      if (in_mode_ff) begin
         // timer tick
         if (running_ff) begin
            tick_count_in = tick_next;
            if (tick_next >= ticks_per_minute_ff) begin
               tick_count_in   = 16'd0;
               minute_count_in = minute_next;
               if (minute_next >= minute_limit_ff) begin
                  relay_in        = 1'b0;
                  minute_count_in = 8'd0;
                  running_in      = 1'b0;
                  action_in       = ACT_LIGHT;
               end
            end
         end
      end else if (in_byte_ff == BYTE_ESCAPE) begin
         phase_in = PH_TAG;
      end else begin
         phase_in = PH_IDLE;
         case (phase_ff)
            PH_TAG: begin
               action_in = ACT_INSTR;
               case (in_byte_ff)
                  TAG_BLOCK_ON:     obyte_in = INSTR_CURSOR_ON;
                  TAG_BLOCK_OFF:    obyte_in = INSTR_CURSOR_OFF;
                  TAG_CLEAR:        obyte_in = INSTR_CLEAR;
                  TAG_BLINK_ON:     obyte_in = INSTR_BLINK_ON;
                  TAG_BLINK_OFF:    obyte_in = INSTR_CURSOR_OFF;
                  TAG_HOME:         obyte_in = INSTR_HOME;
                  TAG_LEFT:         obyte_in = INSTR_LEFT;
                  TAG_RIGHT:        obyte_in = INSTR_RIGHT;
                  TAG_LIGHT_OFF: begin
                     relay_in   = 1'b0;
                     running_in = 1'b0;
                     action_in  = ACT_LIGHT;
                  end
                  TAG_POSITION: begin
                     action_in = ACT_NONE;
                     phase_in  = PH_COLUMN;
                  end
                  TAG_CONTRAST: begin
                     action_in = ACT_NONE;
                     phase_in  = PH_CONTRAST;
                  end
                  TAG_CONTRAST_SAV: begin
                     action_in = ACT_NONE;
                     phase_in  = PH_CONTRAST_SAVE;
                  end
                  TAG_VERSION: begin
                     action_in = ACT_NONE;
                     phase_in  = PH_VERSION;
                  end
                  TAG_GPO_ON: begin
                     action_in = ACT_NONE;
                     phase_in  = PH_GPO_ON;
                  end
                  TAG_GPO_OFF: begin
                     action_in = ACT_NONE;
                     phase_in  = PH_GPO_OFF;
                  end
                  TAG_LIGHT_ON: begin
                     action_in = ACT_NONE;
                     phase_in  = PH_MINUTES;
                  end
                  default: action_in = ACT_NONE;  // unknown tag ignored
               endcase
            end
            PH_COLUMN: begin
               held_column_in = in_byte_ff;
               phase_in       = PH_ROW;
            end
            PH_ROW: begin
               // invalid row or column gives a result with action none
               if (row_base != 8'd0 && held_column_ff >= 8'd1 &&
                   held_column_ff <= {2'b00, display_columns_ff}) begin
                  action_in = ACT_INSTR;
                  obyte_in  = row_base + held_column_ff - 8'd1;
               end
            end
            PH_CONTRAST: begin
               action_in = ACT_DAC;
               obyte_in  = in_byte_ff;
            end
            PH_CONTRAST_SAVE: begin
               action_in = ACT_DAC_SAVE;
               obyte_in  = in_byte_ff;
            end
            PH_VERSION: begin
               action_in = ACT_DATA;
               obyte_in  = in_byte_ff;
            end
            PH_GPO_ON: begin
               if (sel_ok) begin
                  gpo_bits_in = gpo_bits_ff | gpo_mask;
                  action_in   = ACT_GPO;
                  obyte_in    = gpo_bits_ff | gpo_mask;
               end
            end
            PH_GPO_OFF: begin
               if (sel_ok) begin
                  gpo_bits_in = gpo_bits_ff & ~gpo_mask;
                  action_in   = ACT_GPO;
                  obyte_in    = gpo_bits_ff & ~gpo_mask;
               end
            end
            PH_MINUTES: begin
               // zero minutes: relay on, timer not started
               minute_limit_in = in_byte_ff;
               relay_in        = 1'b1;
               if (in_byte_ff != 8'd0) begin
                  running_in = 1'b1;
               end
               action_in = ACT_LIGHT;
               obyte_in  = in_byte_ff;
            end
            default: begin
               // idle or unused phase: plain character
               action_in = ACT_DATA;
               obyte_in  = in_byte_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_minute_ff <= TICKS_PER_MINUTE_RESET;
         display_columns_ff  <= DISPLAY_COLUMNS_RESET;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         phase_ff            <= PH_IDLE;
         held_column_ff      <= 8'd0;
         gpo_bits_ff         <= 8'd0;
         relay_ff            <= 1'b0;
         running_ff          <= 1'b0;
         tick_count_ff       <= 16'd0;
         minute_count_ff     <= 8'd0;
         minute_limit_ff     <= 8'd0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_TICKS_PER_MINUTE: ticks_per_minute_ff <= csr_data;
               CSR_DISPLAY_COLUMNS:  display_columns_ff  <= csr_data[5:0];
               default: ;
            endcase
         end

         // input register
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end

         // result register and state update
         if (advance) begin
            out_valid_ff    <= 1'b1;
            phase_ff        <= phase_in;
            held_column_ff  <= held_column_in;
            gpo_bits_ff     <= gpo_bits_in;
            relay_ff        <= relay_in;
            running_ff      <= running_in;
            tick_count_ff   <= tick_count_in;
            minute_count_ff <= minute_count_in;
            minute_limit_ff <= minute_limit_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_mode_ff <= req_tuser[0];
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_action_ff <= action_in;
         out_byte_ff   <= obyte_in;
         out_light_ff  <= relay_in;
      end
   end

   // a running timer always has the relay on
   assert property (@(posedge clock) disable iff (reset)
      running_ff |-> relay_ff)
      else $error("timer running with relay off");

   // input stalls only when both registers are full and the result is stuck
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without a full pipeline");

   // no action carries no byte
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_action_ff == ACT_NONE) |-> (out_byte_ff == 8'd0))
      else $error("action none with nonzero byte");

   // every item reports the relay state it leaves behind
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_light_ff == relay_ff))
      else $error("reported backlight differs from relay");

endmodule

// ----- tb/serial_lcd_command_decoder_unit_tb.sv -----
// self-checking testbench for the serial lcd command decoder unit
module serial_lcd_command_decoder_unit_tb;
   import slcd_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int LONG_STALL_LEN  = 300;
   localparam int DRAIN_SETTLE    = 4;

   // one serial item: a received byte or a timer tick
   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } serial_item_type;

   // one decoded result item
   typedef struct packed {
      action_type action;
      logic [7:0] out_byte;
      logic       light_on;
   } lcd_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic [0:0]  req_tuser = 1'b0;    // [0] mode

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] out_byte, [8] light_on, [15:9] zero
   logic [2:0]  rsp_tuser;           // [2:0] action

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_TICKS_PER_MINUTE;
   logic [15:0] csr_data = 16'h0000;

   serial_lcd_command_decoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // items waiting to be offered, and decoded results still owed by the block
   serial_item_type serial_items_queued[$];
   lcd_result_type  lcd_results_due[$];

   int unsigned items_queued     = 0;
   int unsigned items_accepted   = 0;
   int unsigned mismatch_count   = 0;
   int unsigned cycle_count      = 0;
   int unsigned send_gap         = 0;
   int unsigned recv_stall       = 0;
   int unsigned long_stall_asks  = 0;
   int unsigned long_stall_seen  = 0;
   logic        idle_enable      = 1'b1;
   logic        req_accepted     = 1'b0;
   logic        csr_accepted     = 1'b0;
   serial_item_type fed_item;
   lcd_result_type  due_result;

   // decoder state as the block should hold it
   phase_type   parse_phase;
   logic [7:0]  held_column;
   logic [7:0]  gpo_bits;
   logic        relay_on;
   logic        timer_on;
   logic [15:0] tick_cnt;
   logic [7:0]  minute_cnt;
   logic [7:0]  minute_lim;
   logic [15:0] cfg_ticks_per_minute;
   logic [5:0]  cfg_columns;

   // work out the result of one accepted item and advance the decoder state
   function automatic lcd_result_type decode_lcd_item(input serial_item_type it);
      lcd_result_type r;
      phase_type   prior;
      logic [7:0]  row_base;
      logic [7:0]  gpo_mask;
      r.action   = ACT_NONE;
      r.out_byte = 8'h00;
      if (it.mode) begin
         // backlight timer only moves while running
         if (timer_on) begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= cfg_ticks_per_minute) begin
               tick_cnt   = 16'd0;
               minute_cnt = minute_cnt + 8'd1;
               if (minute_cnt >= minute_lim) begin
                  relay_on   = 1'b0;
                  minute_cnt = 8'd0;
                  timer_on   = 1'b0;
                  r.action   = ACT_LIGHT;
               end
            end
         end
      end else if (it.rx_byte == BYTE_ESCAPE) begin
         // escape restarts a command, even in place of an argument
         parse_phase = PH_TAG;
      end else begin
         prior       = parse_phase;
         parse_phase = PH_IDLE;
         case (prior)
            PH_TAG: begin
               r.action = ACT_INSTR;
               case (it.rx_byte)
                  TAG_BLOCK_ON:  r.out_byte = INSTR_CURSOR_ON;
                  TAG_BLOCK_OFF: r.out_byte = INSTR_CURSOR_OFF;
                  TAG_CLEAR:     r.out_byte = INSTR_CLEAR;
                  TAG_BLINK_ON:  r.out_byte = INSTR_BLINK_ON;
                  TAG_BLINK_OFF: r.out_byte = INSTR_CURSOR_OFF;
                  TAG_HOME:      r.out_byte = INSTR_HOME;
                  TAG_LEFT:      r.out_byte = INSTR_LEFT;
                  TAG_RIGHT:     r.out_byte = INSTR_RIGHT;
                  TAG_LIGHT_OFF: begin
                     relay_on = 1'b0;
                     timer_on = 1'b0;
                     r.action = ACT_LIGHT;
                  end
                  default: begin
                     // argument tags wait for the next byte, anything else drops
                     r.action = ACT_NONE;
                     case (it.rx_byte)
                        TAG_POSITION:     parse_phase = PH_COLUMN;
                        TAG_CONTRAST:     parse_phase = PH_CONTRAST;
                        TAG_CONTRAST_SAV: parse_phase = PH_CONTRAST_SAVE;
                        TAG_VERSION:      parse_phase = PH_VERSION;
                        TAG_GPO_ON:       parse_phase = PH_GPO_ON;
                        TAG_GPO_OFF:      parse_phase = PH_GPO_OFF;
                        TAG_LIGHT_ON:     parse_phase = PH_MINUTES;
                        default:          parse_phase = PH_IDLE;
                     endcase
                  end
               endcase
            end
            PH_COLUMN: begin
               held_column = it.rx_byte;
               parse_phase = PH_ROW;
            end
            PH_ROW: begin
               case (it.rx_byte)
                  8'd1:    row_base = ROW1_BASE;
                  8'd2:    row_base = ROW2_BASE;
                  8'd3:    row_base = ROW3_BASE;
                  8'd4:    row_base = ROW4_BASE;
                  default: row_base = 8'h00;
               endcase
               // ddram address wraps at 8 bits
               if (row_base != 8'h00 && held_column >= 8'd1
                   && held_column <= {2'b00, cfg_columns}) begin
                  r.action   = ACT_INSTR;
                  r.out_byte = row_base + held_column - 8'd1;
               end
            end
            PH_CONTRAST: begin
               r.action   = ACT_DAC;
               r.out_byte = it.rx_byte;
            end
            PH_CONTRAST_SAVE: begin
               r.action   = ACT_DAC_SAVE;
               r.out_byte = it.rx_byte;
            end
            PH_VERSION: begin
               r.action   = ACT_DATA;
               r.out_byte = it.rx_byte;
            end
            PH_GPO_ON, PH_GPO_OFF: begin
               if (it.rx_byte >= 8'd1 && it.rx_byte <= 8'd8) begin
                  gpo_mask = 8'd1 << (it.rx_byte - 8'd1);
                  if (prior == PH_GPO_ON) gpo_bits = gpo_bits | gpo_mask;
                  else gpo_bits = gpo_bits & ~gpo_mask;
                  r.action   = ACT_GPO;
                  r.out_byte = gpo_bits;
               end
            end
            PH_MINUTES: begin
               // zero minutes turns the relay on and does not start the timer
               minute_lim = it.rx_byte;
               relay_on   = 1'b1;
               if (it.rx_byte != 8'd0) timer_on = 1'b1;
               r.action   = ACT_LIGHT;
               r.out_byte = it.rx_byte;
            end
            default: begin
               r.action   = ACT_DATA;
               r.out_byte = it.rx_byte;
            end
         endcase
      end
      r.light_on = relay_on;
      return r;
   endfunction

   // monitor: predicts on input items, checks result items, tracks register writes
   always @(posedge clock) begin
      req_accepted <= !reset && req_tvalid && req_tready;
      csr_accepted <= !reset && csr_valid && csr_ready;
      if (reset) begin
         parse_phase          = PH_IDLE;
         held_column          = 8'h00;
         gpo_bits             = 8'h00;
         relay_on             = 1'b0;
         timer_on             = 1'b0;
         tick_cnt             = 16'h0000;
         minute_cnt           = 8'h00;
         minute_lim           = 8'h00;
         cfg_ticks_per_minute = TICKS_PER_MINUTE_RESET;
         cfg_columns          = DISPLAY_COLUMNS_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TICKS_PER_MINUTE) cfg_ticks_per_minute = csr_data;
            else cfg_columns = csr_data[5:0];
         end
         // check before predicting so a result can never match its own item
         if (rsp_tvalid && rsp_tready) begin
            if (lcd_results_due.size() == 0) begin
               $display("%0t: result item with none expected, actual action %0d byte %02h",
                        $time, rsp_tuser, rsp_tdata[7:0]);
               mismatch_count++;
            end else begin
               due_result = lcd_results_due.pop_front();
               if (rsp_tuser !== due_result.action) begin
                  $display("%0t: action mismatch, expected %0d, actual %0d",
                           $time, due_result.action, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata[7:0] !== due_result.out_byte) begin
                  $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                           $time, due_result.out_byte, rsp_tdata[7:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[8] !== due_result.light_on) begin
                  $display("%0t: light state mismatch, expected %0b, actual %0b",
                           $time, due_result.light_on, rsp_tdata[8]);
                  mismatch_count++;
               end
               if (rsp_tdata[15:9] !== 7'd0) begin
                  $display("%0t: tdata padding mismatch, expected 0, actual %02h",
                           $time, rsp_tdata[15:9]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            lcd_results_due.push_back(decode_lcd_item({req_tuser[0], req_tdata}));
            items_accepted++;
         end
      end
   end

   // sender: offers queued items, with random gaps after accepted items
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (req_accepted && idle_enable && $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 8);
         if (send_gap != 0) begin
            send_gap = send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (serial_items_queued.size() != 0) begin
            fed_item = serial_items_queued.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= fed_item.rx_byte;
            req_tuser  <= fed_item.mode;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   always @(negedge clock) begin
      if (long_stall_asks != long_stall_seen) begin
         long_stall_seen = long_stall_asks;
         recv_stall      = LONG_STALL_LEN;
      end
      if (recv_stall != 0) begin
         recv_stall = recv_stall - 1;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         recv_stall = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] value);
      serial_items_queued.push_back('{mode: 1'b0, rx_byte: value});
      items_queued++;
   endtask

   // rx_byte is don't-care on a tick, so it carries random bits
   task automatic queue_tick();
      serial_items_queued.push_back('{mode: 1'b1, rx_byte: 8'($urandom_range(0, 255))});
      items_queued++;
   endtask

   task automatic queue_command(input logic [7:0] tag, input logic [7:0] arg);
      queue_byte(BYTE_ESCAPE);
      queue_byte(tag);
      queue_byte(arg);
   endtask

   // one random command, mostly well formed, some noise and broken sequences
   task automatic queue_random_command();
      logic [7:0] simple_tags[9];
      logic [7:0] arg_tags[3];
      int unsigned pick;
      int unsigned burst;
      logic [7:0]  column;
      logic [7:0]  row;
      simple_tags = '{TAG_BLOCK_ON, TAG_BLOCK_OFF, TAG_CLEAR, TAG_BLINK_ON, TAG_BLINK_OFF,
                      TAG_HOME, TAG_LEFT, TAG_RIGHT, TAG_LIGHT_OFF};
      arg_tags    = '{TAG_CONTRAST, TAG_CONTRAST_SAV, TAG_VERSION};
      pick = $urandom_range(0, 99);
      if (pick < 24) begin
         queue_byte(8'($urandom_range(0, 255)));
      end else if (pick < 38) begin
         queue_byte(BYTE_ESCAPE);
         queue_byte(simple_tags[$urandom_range(0, 8)]);
      end else if (pick < 50) begin
         // cursor position, mostly near the valid column range
         if ($urandom_range(0, 9) < 7) column = 8'($urandom_range(0, cfg_columns + 1));
         else column = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 9) < 8) row = 8'($urandom_range(0, 5));
         else row = 8'($urandom_range(0, 255));
         queue_command(TAG_POSITION, column);
         queue_byte(row);
      end else if (pick < 60) begin
         queue_byte(BYTE_ESCAPE);
         queue_byte(arg_tags[$urandom_range(0, 2)]);
         if ($urandom_range(0, 9) == 0) queue_byte(BYTE_ESCAPE);
         queue_byte(8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
         queue_command($urandom_range(0, 1) ? TAG_GPO_ON : TAG_GPO_OFF,
                       ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 9))
                                                 : 8'($urandom_range(0, 255)));
      end else if (pick < 78) begin
         queue_command(TAG_LIGHT_ON,
                       ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 4))
                                                 : 8'($urandom_range(0, 255)));
      end else if (pick < 91) begin
         burst = $urandom_range(1, 24);
         repeat (burst) queue_tick();
      end else begin
         // noise: unknown tags, doubled escapes, position cut short
         case ($urandom_range(0, 2))
            0: begin
               queue_byte(BYTE_ESCAPE);
               queue_byte(8'($urandom_range(0, 255)));
            end
            1: begin
               queue_byte(BYTE_ESCAPE);
               queue_byte(BYTE_ESCAPE);
            end
            default: begin
               queue_byte(BYTE_ESCAPE);
               queue_byte(TAG_POSITION);
               if ($urandom_range(0, 1)) queue_byte(8'($urandom_range(0, 255)));
               if ($urandom_range(0, 1)) queue_tick();
            end
         endcase
      end
   endtask

   // sender pause: everything accepted and every result back, then settle
   task automatic wait_for_drain();
      while (items_accepted != items_queued || lcd_results_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_SETTLE) @(negedge clock);
   endtask

   // register write, only called with the block idle and at a falling edge
   task automatic write_csr(input logic index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_accepted) @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random(input int unsigned count, input logic long_stall);
      int unsigned start;
      start = items_queued;
      while (items_queued - start < count) queue_random_command();
      if (long_stall) long_stall_asks++;
      wait_for_drain();
   endtask

   task automatic run_setting(input logic [15:0] ticks, input logic [5:0] columns,
                              input int unsigned count, input logic long_stall);
      write_csr(CSR_TICKS_PER_MINUTE, ticks);
      write_csr(CSR_DISPLAY_COLUMNS, {10'd0, columns});
      run_random(count, long_stall);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed part under reset configuration
      queue_byte(8'hFF);                                   // plain data, top value
      queue_byte(BYTE_ESCAPE);
      queue_byte(TAG_CLEAR);
      queue_command(TAG_POSITION, 8'd20);                  // last column, last row
      queue_byte(8'd4);
      queue_command(TAG_CONTRAST_SAV, 8'h00);
      queue_command(TAG_GPO_ON, 8'd8);                     // top gpo bit
      queue_command(TAG_GPO_OFF, 8'd9);                    // selector out of range
      queue_command(TAG_LIGHT_ON, 8'd0);                   // backlight on forever
      queue_command(TAG_VERSION, BYTE_ESCAPE);             // escape in place of argument
      queue_byte(TAG_LIGHT_OFF);
      queue_byte(BYTE_ESCAPE);
      queue_byte(8'h40);                                   // startup screen tag ignored
      queue_tick();                                        // tick with timer stopped
      wait_for_drain();

      run_random(280, 1'b0);
      // fast minutes and 40 display columns, receiver holds off once
      run_setting(16'd1, 6'd40, 310, 1'b1);
      // zero ticks per minute: every running tick is a minute
      run_setting(16'd0, 6'd1, 300, 1'b0);
      // largest column code, addresses wrap
      run_setting(16'd4, 6'd63, 310, 1'b0);
      // slowest timer, no valid column
      run_setting(16'hFFFF, 6'd0, 300, 1'b0);
      // last stretch with no idling on either side
      idle_enable = 1'b0;
      run_setting(16'd2, 6'd20, 320, 1'b0);

      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && lcd_results_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/slcd_pkg.sv
hw/rtl/serial_lcd_command_decoder_unit.sv
tb/serial_lcd_command_decoder_unit_tb.sv
